// ----- rtl/esc_pkg.sv -----
`timescale 1ns / 1ps

package esc_pkg;

   localparam int RAW_T_W   = 20;
   localparam int RAW_P_W   = 20;
   localparam int RAW_H_W   = 16;
   localparam int TEMP_W    = 16;
   localparam int PRESS_W   = 32;
   localparam int HUM_W     = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 64;
   localparam int NUM_W     = 64;
   localparam int DEN_W     = 32;
   localparam int DIV_STEPS = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_CAL_TEMP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_PRESS_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_PRESS_B = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_PRESS_C = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_HUM     = 3'd4;

   typedef struct packed {
      logic signed [TEMP_W-1:0] tc;
      logic signed [31:0]       hxs;
      logic signed [31:0]       yh2;
      logic                     neg;
      logic                     dz;
   } side_type;

endpackage

// ----- rtl/esc_req_if.sv -----
`timescale 1ns / 1ps

interface esc_req_if;
   import esc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [RAW_T_W-1:0]   raw_temperature;
   logic [RAW_P_W-1:0]   raw_pressure;
   logic [RAW_H_W-1:0]   raw_humidity;
   modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
   modport sink (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

// ----- rtl/esc_rsp_if.sv -----
`timescale 1ns / 1ps

interface esc_rsp_if;
   import esc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [TEMP_W-1:0]  temperature_centi;
   logic [PRESS_W-1:0]        pressure_milli;
   logic                      pressure_valid;
   logic [HUM_W-1:0]          humidity_q10;
   modport source (output valid, temperature_centi, pressure_milli, pressure_valid,
                   humidity_q10, input ready);
   modport sink (input valid, temperature_centi, pressure_milli, pressure_valid,
                 humidity_q10, output ready);
endinterface

// ----- rtl/esc_div.sv -----
`timescale 1ns / 1ps

// unsigned restoring divider, one quotient bit per stage
module esc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  logic [esc_pkg::NUM_W-1:0]   in_num,
   input  logic [esc_pkg::DEN_W-1:0]   in_den,
   input  esc_pkg::side_type           in_side,
   output logic                        out_vld,
   output logic [esc_pkg::NUM_W-1:0]   out_quo,
   output esc_pkg::side_type           out_side
);
   import esc_pkg::*;

   logic [NUM_W-1:0] num_ff  [DIV_STEPS+1];
   logic [DEN_W-1:0] den_ff  [DIV_STEPS+1];
   logic [DEN_W-1:0] rem_ff  [DIV_STEPS+1];
   logic             vld_ff  [DIV_STEPS+1];
   side_type         side_ff [DIV_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
      if (en) begin
         num_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         rem_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] num_in;

      always_comb begin
         trial  = {rem_ff[k], num_ff[k][NUM_W-1]};
         ge     = (trial >= {1'b0, den_ff[k]});
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff[k]}) : trial[DEN_W-1:0];
         num_in = {num_ff[k][NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (en) begin
            num_ff[k+1]  <= num_in;
            den_ff[k+1]  <= den_ff[k];
            rem_ff[k+1]  <= rem_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_vld  = vld_ff[DIV_STEPS];
   assign out_quo  = num_ff[DIV_STEPS];
   assign out_side = side_ff[DIV_STEPS];

endmodule

// ----- rtl/env_sensor_compensation.sv -----
`timescale 1ns / 1ps

// channel   | dir | contents
// req_chan  | in  | raw temperature, pressure, humidity readings
// rsp_chan  | out | temperature, pressure, pressure valid, humidity
// csr_*     | in  | calibration register writes
//
// One transaction enters per cycle unless the output stalls. The pipeline has 10
// front, 65 divider and 5 back stages; one bit per divider stage sets the depth.
// Synchronous reset clears valid bits and calibration registers.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module env_sensor_compensation (
   input  logic                              clock,
   input  logic                              reset,
   esc_req_if.sink                           req_chan,
   esc_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [esc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [esc_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import esc_pkg::*;

   logic [47:0] cal_temp_ff;
   logic [63:0] cal_pa_ff;
   logic [63:0] cal_pb_ff;
   logic [15:0] cal_pc_ff;
   logic [63:0] cal_hum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff <= '0;
         cal_pa_ff   <= '0;
         cal_pb_ff   <= '0;
         cal_pc_ff   <= '0;
         cal_hum_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAL_TEMP:    cal_temp_ff <= csr_wdata[47:0];
            CSR_CAL_PRESS_A: cal_pa_ff   <= csr_wdata;
            CSR_CAL_PRESS_B: cal_pb_ff   <= csr_wdata;
            CSR_CAL_PRESS_C: cal_pc_ff   <= csr_wdata[15:0];
            CSR_CAL_HUM:     cal_hum_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic signed [31:0] h1, h2, h3, h4, h5, h6;

   assign t1 = $signed({48'd0, cal_temp_ff[15:0]});
   assign t2 = $signed({{48{cal_temp_ff[31]}}, cal_temp_ff[31:16]});
   assign t3 = $signed({{48{cal_temp_ff[47]}}, cal_temp_ff[47:32]});
   assign p1 = $signed({48'd0, cal_pa_ff[15:0]});
   assign p2 = $signed({{48{cal_pa_ff[31]}}, cal_pa_ff[31:16]});
   assign p3 = $signed({{48{cal_pa_ff[47]}}, cal_pa_ff[47:32]});
   assign p4 = $signed({{48{cal_pa_ff[63]}}, cal_pa_ff[63:48]});
   assign p5 = $signed({{48{cal_pb_ff[15]}}, cal_pb_ff[15:0]});
   assign p6 = $signed({{48{cal_pb_ff[31]}}, cal_pb_ff[31:16]});
   assign p7 = $signed({{48{cal_pb_ff[47]}}, cal_pb_ff[47:32]});
   assign p8 = $signed({{48{cal_pb_ff[63]}}, cal_pb_ff[63:48]});
   assign p9 = $signed({{48{cal_pc_ff[15]}}, cal_pc_ff});
   assign h1 = $signed({24'd0, cal_hum_ff[7:0]});
   assign h2 = $signed({{16{cal_hum_ff[23]}}, cal_hum_ff[23:8]});
   assign h3 = $signed({24'd0, cal_hum_ff[31:24]});
   assign h4 = $signed({{20{cal_hum_ff[43]}}, cal_hum_ff[43:32]});
   assign h5 = $signed({{20{cal_hum_ff[55]}}, cal_hum_ff[55:44]});
   assign h6 = $signed({{24{cal_hum_ff[63]}}, cal_hum_ff[63:56]});

   logic adv;
   logic out_vld_ff;
   assign adv            = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // front valid chain, stages 1..10
   logic [10:1] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[9:1], req_chan.valid};
      end
   end

   // stage 1
   logic [RAW_T_W-1:0] rt1_ff;
   logic [RAW_P_W-1:0] rp1_ff;
   logic [RAW_H_W-1:0] rh1_ff;

   // stage 2
   logic signed [63:0] at2_2_ff, bb2_ff, at2_2_in, bb2_in;
   logic [RAW_P_W-1:0] rp2_ff;
   logic [RAW_H_W-1:0] rh2_ff;
   logic signed [63:0] a_t, b_t;

   always_comb begin
      a_t      = ($signed({44'd0, rt1_ff}) >>> 3) - (t1 <<< 1);
      b_t      = ($signed({44'd0, rt1_ff}) >>> 4) - t1;
      at2_2_in = a_t * t2;
      bb2_in   = b_t * b_t;
   end

   // stage 3
   logic signed [63:0] ta3_ff, m3_ff, ta3_in, m3_in;
   logic [RAW_P_W-1:0] rp3_ff;
   logic [RAW_H_W-1:0] rh3_ff;
   always_comb begin
      ta3_in = at2_2_ff >>> 11;
      m3_in  = (bb2_ff >>> 12) * t3;
   end

   // stage 4
   logic signed [63:0] tf4_ff, tf4_in;
   logic signed [31:0] hv4_ff, hv4_in;
   logic [RAW_P_W-1:0] rp4_ff;
   logic [RAW_H_W-1:0] rh4_ff;
   always_comb begin
      tf4_in = ta3_ff + (m3_ff >>> 14);
      hv4_in = tf4_in[31:0] - 32'sd76800;
   end

   // stage 5
   logic signed [TEMP_W-1:0] tc5_ff, tc5_in;
   logic signed [63:0] qq5_ff, qp5_5_ff, qp2_5_ff, qq5_in, qp5_5_in, qp2_5_in;
   logic signed [31:0] hx5_ff, hx5_in, hv5_ff;
   logic [RAW_P_W-1:0] rp5_ff;
   logic signed [63:0] tc_w, q1_w;
   always_comb begin
      tc_w = (tf4_ff * 64'sd5 + 64'sd128) >>> 8;
      if (tc_w > 64'sd32767) begin
         tc5_in = 16'sd32767;
      end else if (tc_w < -64'sd32768) begin
         tc5_in = -16'sd32768;
      end else begin
         tc5_in = tc_w[15:0];
      end
      q1_w     = tf4_ff - 64'sd128000;
      qq5_in   = q1_w * q1_w;
      qp5_5_in = q1_w * p5;
      qp2_5_in = q1_w * p2;
      hx5_in   = $signed({2'b00, rh4_ff, 14'd0}) - (h4 <<< 20) - h5 * hv4_ff;
   end

   // stage 6
   logic signed [TEMP_W-1:0] tc6_ff;
   logic signed [63:0] q2a6_ff, q1a6_ff, qp5_6_ff, qp2_6_ff, q2a6_in, q1a6_in;
   logic signed [31:0] hxs6_ff, hy1_6_ff, hz1_6_ff, hxs6_in, hy1_6_in, hz1_6_in;
   logic [RAW_P_W-1:0] rp6_ff;
   always_comb begin
      q2a6_in  = qq5_ff * p6;
      q1a6_in  = qq5_ff * p3;
      hxs6_in  = (hx5_ff + 32'sd16384) >>> 15;
      hy1_6_in = hv5_ff * h6;
      hz1_6_in = hv5_ff * h3;
   end

   // stage 7
   logic signed [TEMP_W-1:0] tc7_ff;
   logic signed [63:0] q2_7_ff, q1b7_ff, q2_7_in, q1b7_in;
   logic signed [31:0] hxs7_ff, hy7_ff, hz7_ff, hy7_in, hz7_in;
   logic [RAW_P_W-1:0] rp7_ff;
   always_comb begin
      q2_7_in = q2a6_ff + (qp5_6_ff <<< 17) + (p4 <<< 35);
      q1b7_in = (q1a6_ff >>> 8) + (qp2_6_ff <<< 12);
      hy7_in  = hy1_6_ff >>> 10;
      hz7_in  = (hz1_6_ff >>> 11) + 32'sd32768;
   end

   // stage 8
   logic signed [TEMP_W-1:0] tc8_ff;
   logic signed [63:0] q1c8_ff, pn0_8_ff, q1c8_in, pn0_8_in;
   logic signed [31:0] hxs8_ff, hyz8_ff, hyz8_in;
   always_comb begin
      q1c8_in  = ((64'sd1 <<< 47) + q1b7_ff) * p1;
      pn0_8_in = ((64'sd1048576 - $signed({44'd0, rp7_ff})) <<< 31) - q2_7_ff;
      hyz8_in  = hy7_ff * hz7_ff;
   end

   // stage 9
   logic signed [TEMP_W-1:0] tc9_ff;
   logic signed [63:0] q1d9_ff, pn9_ff, q1d9_in, pn9_in;
   logic signed [31:0] hxs9_ff, hy2_9_ff, hy2_9_in;
   always_comb begin
      q1d9_in  = q1c8_ff >>> 33;
      pn9_in   = pn0_8_ff * 64'sd3125;
      hy2_9_in = (hyz8_ff >>> 10) + 32'sd2097152;
   end

   // stage 10: divider operands
   logic [NUM_W-1:0] num10_ff, num10_in;
   logic [DEN_W-1:0] den10_ff, den10_in;
   side_type         side10_ff, side10_in;
   logic signed [63:0] dabs;
   always_comb begin
      num10_in      = pn9_ff[63] ? NUM_W'(-pn9_ff) : NUM_W'(pn9_ff);
      dabs          = q1d9_ff[63] ? -q1d9_ff : q1d9_ff;
      den10_in      = dabs[DEN_W-1:0];
      side10_in.tc  = tc9_ff;
      side10_in.hxs = hxs9_ff;
      side10_in.yh2 = hy2_9_ff * h2;
      side10_in.neg = pn9_ff[63] ^ q1d9_ff[63];
      side10_in.dz  = (q1d9_ff == 64'sd0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rt1_ff    <= req_chan.raw_temperature;
         rp1_ff    <= req_chan.raw_pressure;
         rh1_ff    <= req_chan.raw_humidity;
         at2_2_ff  <= at2_2_in;
         bb2_ff    <= bb2_in;
         rp2_ff    <= rp1_ff;
         rh2_ff    <= rh1_ff;
         ta3_ff    <= ta3_in;
         m3_ff     <= m3_in;
         rp3_ff    <= rp2_ff;
         rh3_ff    <= rh2_ff;
         tf4_ff    <= tf4_in;
         hv4_ff    <= hv4_in;
         rp4_ff    <= rp3_ff;
         rh4_ff    <= rh3_ff;
         tc5_ff    <= tc5_in;
         qq5_ff    <= qq5_in;
         qp5_5_ff  <= qp5_5_in;
         qp2_5_ff  <= qp2_5_in;
         hx5_ff    <= hx5_in;
         hv5_ff    <= hv4_ff;
         rp5_ff    <= rp4_ff;
         tc6_ff    <= tc5_ff;
         q2a6_ff   <= q2a6_in;
         q1a6_ff   <= q1a6_in;
         qp5_6_ff  <= qp5_5_ff;
         qp2_6_ff  <= qp2_5_ff;
         hxs6_ff   <= hxs6_in;
         hy1_6_ff  <= hy1_6_in;
         hz1_6_ff  <= hz1_6_in;
         rp6_ff    <= rp5_ff;
         tc7_ff    <= tc6_ff;
         q2_7_ff   <= q2_7_in;
         q1b7_ff   <= q1b7_in;
         hxs7_ff   <= hxs6_ff;
         hy7_ff    <= hy7_in;
         hz7_ff    <= hz7_in;
         rp7_ff    <= rp6_ff;
         tc8_ff    <= tc7_ff;
         q1c8_ff   <= q1c8_in;
         pn0_8_ff  <= pn0_8_in;
         hxs8_ff   <= hxs7_ff;
         hyz8_ff   <= hyz8_in;
         tc9_ff    <= tc8_ff;
         q1d9_ff   <= q1d9_in;
         pn9_ff    <= pn9_in;
         hxs9_ff   <= hxs8_ff;
         hy2_9_ff  <= hy2_9_in;
         num10_ff  <= num10_in;
         den10_ff  <= den10_in;
         side10_ff <= side10_in;
      end
   end

   logic             dv_vld;
   logic [NUM_W-1:0] dv_quo;
   side_type         dv_side;

   esc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (vld_ff[10]),
      .in_num   (num10_ff),
      .in_den   (den10_ff),
      .in_side  (side10_ff),
      .out_vld  (dv_vld),
      .out_quo  (dv_quo),
      .out_side (dv_side)
   );

   // back stages a..d, then the output register
   logic [3:0] bvld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         bvld_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         bvld_ff    <= {bvld_ff[2:0], dv_vld};
         out_vld_ff <= bvld_ff[3];
      end
   end

   // a
   logic signed [63:0] pa_ff, pa_in;
   logic signed [31:0] hv2a_ff, hv2a_in, hyy;
   logic signed [TEMP_W-1:0] tca_ff;
   logic dza_ff;
   always_comb begin
      pa_in   = dv_side.neg ? -$signed(dv_quo) : $signed(dv_quo);
      hyy     = (dv_side.yh2 + 32'sd8192) >>> 14;
      hv2a_in = dv_side.hxs * hyy;
   end

   // b
   logic signed [63:0] pb_ff, r1ab_ff, r2mb_ff, r1ab_in, r2mb_in;
   logic signed [31:0] hv2b_ff, ssb_ff, ssb_in, s0;
   logic signed [TEMP_W-1:0] tcb_ff;
   logic dzb_ff;
   always_comb begin
      r1ab_in = p9 * (pa_ff >>> 13);
      r2mb_in = p8 * pa_ff;
      s0      = hv2a_ff >>> 15;
      ssb_in  = s0 * s0;
   end

   // c: low 64 bits of the wide product from three 32x32 partial products
   logic signed [63:0] pc_ff, r1bc_ff, r2c_ff, r1bc_in;
   logic [63:0] r1sh, r1ll;
   logic [31:0] r1hl, r1lh;
   logic signed [31:0] hv2c_ff, shc_ff, shc_in;
   logic signed [TEMP_W-1:0] tcc_ff;
   logic dzc_ff;
   always_comb begin
      r1sh    = pb_ff >>> 13;
      r1ll    = 64'(r1ab_ff[31:0]) * 64'(r1sh[31:0]);
      r1hl    = r1ab_ff[63:32] * r1sh[31:0];
      r1lh    = r1ab_ff[31:0] * r1sh[63:32];
      r1bc_in = $signed(r1ll + {r1hl + r1lh, 32'd0});
      shc_in  = (ssb_ff >>> 7) * h1;
   end

   // d
   logic signed [63:0] ppd_ff, ppd_in;
   logic [HUM_W-1:0] humd_ff, humd_in;
   logic signed [31:0] hv3;
   logic signed [TEMP_W-1:0] tcd_ff;
   logic dzd_ff;
   always_comb begin
      ppd_in = ((pc_ff + (r1bc_ff >>> 25) + r2c_ff) >>> 8) + (p7 <<< 4);
      hv3    = hv2c_ff - (shc_ff >>> 4);
      if (hv3 < 32'sd0) begin
         humd_in = '0;
      end else if (hv3 > 32'sd419430400) begin
         humd_in = HUM_W'(32'd419430400 >> 12);
      end else begin
         humd_in = hv3[28:12];
      end
   end

   // output register
   logic signed [TEMP_W-1:0] tco_ff;
   logic [PRESS_W-1:0] presso_ff, presso_in;
   logic pvo_ff;
   logic [HUM_W-1:0] humo_ff;
   logic signed [63:0] pint;
   logic [63:0] psum;
   always_comb begin
      pint = ppd_ff >>> 8;
      psum = 64'(pint) * 64'd1000 + ((64'(ppd_ff[7:0]) * 64'd125) >> 5);
      if (dzd_ff || ppd_ff < 64'sd0) begin
         presso_in = '0;
      end else if (pint > 64'sd4294967 || psum > 64'hFFFF_FFFF) begin
         presso_in = '1;
      end else begin
         presso_in = psum[PRESS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff     <= pa_in;
         hv2a_ff   <= hv2a_in;
         tca_ff    <= dv_side.tc;
         dza_ff    <= dv_side.dz;
         pb_ff     <= pa_ff;
         r1ab_ff   <= r1ab_in;
         r2mb_ff   <= r2mb_in;
         hv2b_ff   <= hv2a_ff;
         ssb_ff    <= ssb_in;
         tcb_ff    <= tca_ff;
         dzb_ff    <= dza_ff;
         pc_ff     <= pb_ff;
         r1bc_ff   <= r1bc_in;
         r2c_ff    <= r2mb_ff >>> 19;
         hv2c_ff   <= hv2b_ff;
         shc_ff    <= shc_in;
         tcc_ff    <= tcb_ff;
         dzc_ff    <= dzb_ff;
         ppd_ff    <= ppd_in;
         humd_ff   <= humd_in;
         tcd_ff    <= tcc_ff;
         dzd_ff    <= dzc_ff;
         tco_ff    <= tcd_ff;
         presso_ff <= presso_in;
         pvo_ff    <= !dzd_ff;
         humo_ff   <= humd_ff;
      end
   end

   assign rsp_chan.valid             = out_vld_ff;
   assign rsp_chan.temperature_centi = tco_ff;
   assign rsp_chan.pressure_milli    = presso_ff;
   assign rsp_chan.pressure_valid    = pvo_ff;
   assign rsp_chan.humidity_q10      = humo_ff;

endmodule
